// ===== sv/fprq_pkg.sv =====
// shared types and constants for the four-level priority ready queue
// no dependencies
package fprq_pkg;

  localparam int unsigned LEVELS = 4;

  typedef enum logic [1:0] {
    MODE_INS_AHEAD  = 2'd0,
    MODE_INS_BEHIND = 2'd1,
    MODE_REMOVE     = 2'd2,
    MODE_ROTATE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_PRIO  = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UPD,
    S_HRD,
    S_RESP
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic exec;
    logic upd;
    logic head_rd;
    logic resp;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

// ===== sv/fprq_ctrl.sv =====
// controller state machine for the ready queue
// depends on fprq_pkg
module fprq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fprq_pkg::stat_t stat,
  output fprq_pkg::cmd_t  cmd
);
  import fprq_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_UPD;
      S_UPD:  state_nxt = S_HRD;
      S_HRD:  state_nxt = S_RESP;
      S_RESP: if (!stat.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_UPD:  cmd.upd = 1'b1;
      S_HRD:  cmd.head_rd = 1'b1;
      S_RESP: cmd.resp = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/fprq_dp.sv =====
// datapath: level lists, link and id memories, result register
// depends on fprq_pkg
module fprq_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  fprq_pkg::cmd_t  cmd,
  output fprq_pkg::stat_t stat,
  input  logic [1:0]      in_mode,
  input  logic [15:0]     in_task_id,
  input  logic [3:0]      in_task_priority,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output logic            out_removed_valid,
  output logic [15:0]     out_removed_id,
  output logic [2:0]      out_removed_priority,
  output logic            out_head_valid,
  output logic [15:0]     out_head_id,
  output logic [2:0]      out_head_priority,
  output logic [6:0]      out_entry_count
);
  import fprq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // memories
  logic [AW-1:0] link_mem [DEPTH];
  logic [15:0]   id_mem   [DEPTH];
  logic [AW-1:0] link_q_r;
  logic [15:0]   id_q_r;

  // held item
  logic [1:0]  mode_r;
  logic [15:0] tid_r;
  logic [3:0]  prio_r;

  // list state
  logic [AW-1:0] lhead_r [LEVELS];
  logic [AW-1:0] ltail_r [LEVELS];
  logic [CW-1:0] locc_r  [LEVELS];
  logic [AW-1:0] lhead_nxt [LEVELS];
  logic [AW-1:0] ltail_nxt [LEVELS];
  logic [CW-1:0] locc_nxt  [LEVELS];
  logic [AW-1:0] free_head_r, free_head_nxt;
  logic [CW-1:0] fresh_r, fresh_nxt;
  logic [CW-1:0] total_r, total_nxt;

  // per-item results
  status_t     st_r;
  logic [1:0]  hl_r;
  logic        rv_r;
  logic [15:0] rid_r;
  logic [2:0]  rpri_r;
  logic        hv_r;
  logic [1:0]  hpl_r;

  // output register
  logic        out_valid_r;
  logic [1:0]  ost_r;
  logic        orv_r;
  logic [15:0] orid_r;
  logic [2:0]  orpri_r;
  logic        ohv_r;
  logic [15:0] ohid_r;
  logic [2:0]  ohpri_r;
  logic [6:0]  ocnt_r;

  // head level search
  logic       any_occ;
  logic [1:0] cur_lv;
  always_comb begin
    any_occ = 1'b0;
    cur_lv  = 2'd0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (locc_r[i] != '0) begin
        any_occ = 1'b1;
        cur_lv  = 2'(i);
      end
    end
  end

  // status check and memory read address
  status_t       st_chk;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          is_ins;
  assign is_ins = (mode_r == MODE_INS_AHEAD) || (mode_r == MODE_INS_BEHIND);
  always_comb begin
    st_chk = ST_OK;
    if (is_ins) begin
      if (prio_r == 4'd0 || prio_r > 4'd4) st_chk = ST_BAD_PRIO;
      else if (total_r >= CW'(DEPTH))      st_chk = ST_FULL;
    end else if (!any_occ) begin
      st_chk = ST_EMPTY;
    end
    rd_en   = cmd.exec || cmd.head_rd;
    rd_addr = is_ins ? free_head_r : lhead_r[cur_lv];
    if (cmd.head_rd) rd_addr = lhead_r[cur_lv];
  end

  // list update
  logic          link_we, id_we;
  logic [AW-1:0] link_wa, id_wa, link_wd;
  logic [1:0]    ilv, nl;
  logic          recycled;
  logic [AW-1:0] slot;
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      lhead_nxt[i] = lhead_r[i];
      ltail_nxt[i] = ltail_r[i];
      locc_nxt[i]  = locc_r[i];
    end
    free_head_nxt = free_head_r;
    fresh_nxt     = fresh_r;
    total_nxt     = total_r;
    link_we = 1'b0;
    id_we   = 1'b0;
    link_wa = '0;
    link_wd = '0;
    id_wa   = '0;
    ilv      = 2'(prio_r - 4'd1);
    nl       = (hl_r == 2'd3) ? 2'd3 : hl_r + 2'd1;
    recycled = (fresh_r != total_r);
    slot     = recycled ? free_head_r : AW'(fresh_r);
    if (cmd.upd && st_r == ST_OK) begin
      if (is_ins) begin
        // take a slot: recycled list first, then never-used slots
        if (recycled) free_head_nxt = link_q_r;
        else          fresh_nxt = fresh_r + 1'b1;
        id_we = 1'b1;
        id_wa = slot;
        if (locc_r[ilv] == '0) begin
          lhead_nxt[ilv] = slot;
          ltail_nxt[ilv] = slot;
        end else if (mode_r == MODE_INS_AHEAD) begin
          link_we = 1'b1;
          link_wa = slot;
          link_wd = lhead_r[ilv];
          lhead_nxt[ilv] = slot;
        end else begin
          link_we = 1'b1;
          link_wa = ltail_r[ilv];
          link_wd = slot;
          ltail_nxt[ilv] = slot;
        end
        locc_nxt[ilv] = locc_r[ilv] + 1'b1;
        total_nxt     = total_r + 1'b1;
      end else begin
        // unlink the head
        lhead_nxt[hl_r] = link_q_r;
        locc_nxt[hl_r]  = locc_r[hl_r] - 1'b1;
        if (mode_r == MODE_REMOVE) begin
          link_we       = 1'b1;
          link_wa       = lhead_r[hl_r];
          link_wd       = free_head_r;
          free_head_nxt = lhead_r[hl_r];
          total_nxt     = total_r - 1'b1;
        end else begin
          // the same slot goes behind the demoted level
          if (locc_nxt[nl] == '0) begin
            lhead_nxt[nl] = lhead_r[hl_r];
          end else begin
            link_we = 1'b1;
            link_wa = ltail_r[nl];
            link_wd = lhead_r[hl_r];
          end
          ltail_nxt[nl] = lhead_r[hl_r];
          locc_nxt[nl]  = locc_nxt[nl] + 1'b1;
        end
      end
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (id_we)   id_mem[id_wa] <= tid_r;
    if (rd_en) begin
      link_q_r <= link_mem[rd_addr];
      id_q_r   <= id_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        lhead_r[i] <= '0;
        ltail_r[i] <= '0;
        locc_r[i]  <= '0;
      end
      free_head_r <= '0;
      fresh_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < LEVELS; i++) begin
        lhead_r[i] <= lhead_nxt[i];
        ltail_r[i] <= ltail_nxt[i];
        locc_r[i]  <= locc_nxt[i];
      end
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      total_r     <= total_nxt;
      if (cmd.resp)          out_valid_r <= 1'b1;
      else if (out_ready)    out_valid_r <= 1'b0;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_mode;
      tid_r  <= in_task_id;
      prio_r <= in_task_priority;
    end
    if (cmd.exec) begin
      st_r <= st_chk;
      hl_r <= cur_lv;
    end
    if (cmd.upd) begin
      rv_r   <= (st_r == ST_OK) && !is_ins;
      rid_r  <= ((st_r == ST_OK) && !is_ins) ? id_q_r : 16'd0;
      rpri_r <= ((st_r == ST_OK) && !is_ins) ? {1'b0, hl_r} + 3'd1 : 3'd0;
    end
    if (cmd.head_rd) begin
      hv_r  <= any_occ;
      hpl_r <= cur_lv;
    end
    if (cmd.resp) begin
      ost_r   <= st_r;
      orv_r   <= rv_r;
      orid_r  <= rid_r;
      orpri_r <= rpri_r;
      ohv_r   <= hv_r;
      ohid_r  <= hv_r ? id_q_r : 16'd0;
      ohpri_r <= hv_r ? {1'b0, hpl_r} + 3'd1 : 3'd0;
      ocnt_r  <= 7'(total_r);
    end
  end

  assign stat.out_busy        = out_valid_r && !out_ready;
  assign out_valid            = out_valid_r;
  assign out_status           = ost_r;
  assign out_removed_valid    = orv_r;
  assign out_removed_id       = orid_r;
  assign out_removed_priority = orpri_r;
  assign out_head_valid       = ohv_r;
  assign out_head_id          = ohid_r;
  assign out_head_priority    = ohpri_r;
  assign out_entry_count      = ocnt_r;

  logic [CW+1:0] occ_sum;
  assign occ_sum = (CW+2)'(locc_r[0]) + (CW+2)'(locc_r[1])
                 + (CW+2)'(locc_r[2]) + (CW+2)'(locc_r[3]);

  a_occ_sum: assert property (@(posedge clk) disable iff (!rst_n)
    occ_sum == (CW+2)'(total_r)) else $error("level counts disagree with total");
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CW'(DEPTH) && fresh_r <= CW'(DEPTH)) else $error("count beyond depth");
  a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r >= total_r) else $error("more entries than slots handed out");
  a_rot_keep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd && mode_r == MODE_ROTATE |=> $stable(total_r))
    else $error("rotate changed the count");

endmodule

// ===== sv/four_level_priority_ready_queue.sv =====
// top level of the four-level priority ready queue
// instantiates fprq_ctrl and fprq_dp, depends on fprq_pkg
//
//  channel | ports                                   | direction
//  in      | in_valid/in_ready, mode, task_id, prio  | input word
//  out     | out_valid/out_ready, eight result fields| result word
//
// a word goes from accept to result in these steps: accept, head search and
// memory read, list update, head id read, result load (link/id memory ports).
// the next word is taken once the result is loaded, while it waits on out.
// a full out register holds the controller in its result step.
// reset is synchronous; never-used slots are handed out by a fill count,
// so no clearing pass follows reset.
module four_level_priority_ready_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_task_id,
  input  logic [3:0]  in_task_priority,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_removed_valid,
  output logic [15:0] out_removed_id,
  output logic [2:0]  out_removed_priority,
  output logic        out_head_valid,
  output logic [15:0] out_head_id,
  output logic [2:0]  out_head_priority,
  output logic [6:0]  out_entry_count
);
  import fprq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  fprq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // lists and memories
  fprq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_mode              (in_mode),
    .in_task_id           (in_task_id),
    .in_task_priority     (in_task_priority),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_removed_valid    (out_removed_valid),
    .out_removed_id       (out_removed_id),
    .out_removed_priority (out_removed_priority),
    .out_head_valid       (out_head_valid),
    .out_head_id          (out_head_id),
    .out_head_priority    (out_head_priority),
    .out_entry_count      (out_entry_count)
  );

endmodule
